>>> rtl/mw3_pkg.sv
// ----------------------------------------------------------------------------
// mw3_pkg
// Shared types, constants and microcode table for the word-stream hasher.
// ----------------------------------------------------------------------------
package mw3_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int CNT_W   = 32;
    localparam int UPC_W   = 5;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    localparam logic [WORD_W-1:0] MIX_C1    = 64'h87c3_7b91_1142_53d5;
    localparam logic [WORD_W-1:0] MIX_C2    = 64'h4cf5_ad43_2745_937f;
    localparam logic [WORD_W-1:0] ROUND_ADD = 64'h0000_0000_52dc_e729;
    localparam logic [WORD_W-1:0] FMIX_M1   = 64'hff51_afd7_ed55_8ccd;
    localparam logic [WORD_W-1:0] FMIX_M2   = 64'hc4ce_b9fe_1a85_ec53;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 32'hffff_ffff;

    // register index = paddr[3]
    localparam logic REG_SEED = 1'b0;

    typedef enum logic [1:0] {
        K_C1,
        K_C2,
        K_M1,
        K_M2
    } t_kst;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADDHI
    } t_acc_op;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_ROT31,
        ALU_ROUND,
        ALU_FIN,
        ALU_XS,
        ALU_OUT
    } t_alu_op;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_END_IF_MORE,
        SEQ_EMIT
    } t_seq_op;

    typedef struct packed {
        logic    mul_en;
        logic    x_hi;
        t_kst    kst;
        logic    k_hi;
        t_acc_op acc;
        t_alu_op alu;
        t_seq_op seq;
    } t_uword;

    localparam t_uword UW_NOP = '{
        mul_en: 1'b0, x_hi: 1'b0, kst: K_C1, k_hi: 1'b0,
        acc: ACC_NONE, alu: ALU_NONE, seq: SEQ_NEXT
    };

    function automatic logic [WORD_W-1:0] kconst(input t_kst k);
        logic [WORD_W-1:0] v;
        v = MIX_C1;
        unique case (k)
            K_C1: v = MIX_C1;
            K_C2: v = MIX_C2;
            K_M1: v = FMIX_M1;
            K_M2: v = FMIX_M2;
            default: v = MIX_C1;
        endcase
        return v;
    endfunction

    // 64x64 low product as lo*lo + (lo*hi + hi*lo) << 32, one partial a step
    function automatic t_uword mul_step(input t_kst k, input logic [1:0] ph);
        t_uword u;
        u     = UW_NOP;
        u.kst = k;
        unique case (ph)
            2'd0: begin
                u.mul_en = 1'b1;
            end
            2'd1: begin
                u.mul_en = 1'b1;
                u.k_hi   = 1'b1;
                u.acc    = ACC_LOAD;
            end
            2'd2: begin
                u.mul_en = 1'b1;
                u.x_hi   = 1'b1;
                u.acc    = ACC_ADDHI;
            end
            default: begin
                u.acc = ACC_ADDHI;
            end
        endcase
        return u;
    endfunction

    function automatic t_uword alu_step(input t_alu_op op, input t_seq_op sq);
        t_uword u;
        u     = UW_NOP;
        u.alu = op;
        u.seq = sq;
        return u;
    endfunction

    function automatic t_uword ucode_rom(input logic [UPC_W-1:0] upc);
        t_uword u;
        u = alu_step(ALU_NONE, SEQ_EMIT);
        unique case (upc)
            5'd0:  u = mul_step(K_C1, 2'd0);
            5'd1:  u = mul_step(K_C1, 2'd1);
            5'd2:  u = mul_step(K_C1, 2'd2);
            5'd3:  u = mul_step(K_C1, 2'd3);
            5'd4:  u = alu_step(ALU_ROT31, SEQ_NEXT);
            5'd5:  u = mul_step(K_C2, 2'd0);
            5'd6:  u = mul_step(K_C2, 2'd1);
            5'd7:  u = mul_step(K_C2, 2'd2);
            5'd8:  u = mul_step(K_C2, 2'd3);
            5'd9:  u = alu_step(ALU_ROUND, SEQ_END_IF_MORE);
            5'd10: u = alu_step(ALU_FIN, SEQ_NEXT);
            5'd11: u = mul_step(K_M1, 2'd0);
            5'd12: u = mul_step(K_M1, 2'd1);
            5'd13: u = mul_step(K_M1, 2'd2);
            5'd14: u = mul_step(K_M1, 2'd3);
            5'd15: u = alu_step(ALU_XS, SEQ_NEXT);
            5'd16: u = mul_step(K_M2, 2'd0);
            5'd17: u = mul_step(K_M2, 2'd1);
            5'd18: u = mul_step(K_M2, 2'd2);
            5'd19: u = mul_step(K_M2, 2'd3);
            5'd20: u = alu_step(ALU_OUT, SEQ_EMIT);
            default: u = alu_step(ALU_NONE, SEQ_EMIT);
        endcase
        return u;
    endfunction

endpackage

>>> rtl/mw3_in_if.sv
// ----------------------------------------------------------------------------
// mw3_in_if
// Input item channel: one 64-bit word and its last-of-message flag.
// ----------------------------------------------------------------------------
interface mw3_in_if import mw3_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;
    logic              last;

    modport source (output valid, output word, output last, input ready);
    modport sink   (input valid, input word, input last, output ready);
endinterface

>>> rtl/mw3_out_if.sv
// ----------------------------------------------------------------------------
// mw3_out_if
// Result item channel: one finished 64-bit hash.
// ----------------------------------------------------------------------------
interface mw3_out_if import mw3_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] hash_out;

    modport source (output valid, output hash_out, input ready);
    modport sink   (input valid, input hash_out, output ready);
endinterface

>>> rtl/mw3_seq.sv
// ----------------------------------------------------------------------------
// mw3_seq
// Microcode sequencer: step counter, control store and conditional ends.
// ----------------------------------------------------------------------------
module mw3_seq import mw3_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_last,
    input  logic   i_out_full,
    output logic   o_busy,
    output t_uword o_uw
);

    logic             r_busy;
    logic [UPC_W-1:0] r_upc;
    logic             n_busy;
    logic [UPC_W-1:0] n_upc;
    t_uword           rom_uw;

    assign rom_uw = ucode_rom(r_upc);
    assign o_uw   = r_busy ? rom_uw : UW_NOP;
    assign o_busy = r_busy;

    always_comb begin
        n_busy = r_busy;
        n_upc  = r_upc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_upc  = '0;
            end
        end else begin
            case (rom_uw.seq)
                SEQ_NEXT: begin
                    n_upc = r_upc + 1'b1;
                end
                SEQ_END_IF_MORE: begin
                    if (i_last) begin
                        n_upc = r_upc + 1'b1;
                    end else begin
                        n_busy = 1'b0;
                        n_upc  = '0;
                    end
                end
                SEQ_EMIT: begin
                    if (!i_out_full) begin
                        n_busy = 1'b0;
                        n_upc  = '0;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                    n_upc  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= '0;
        end else begin
            r_busy <= n_busy;
            r_upc  <= n_upc;
        end
    end

endmodule

>>> rtl/murmur3_word_stream_hash.sv
// ----------------------------------------------------------------------------
// murmur3_word_stream_hash
// Word-stream 64-bit MurmurHash3: per-word block mix and round, fmix64 finish.
// A new word is accepted only while the sequencer is idle, once the previous word is
// through; the hash waits while the output is full. One 32x32 multiplier does
// three partial products per 64-bit multiply under the microcode sequencer.
// Reset: sequencer idle, word count 0, seed 0, output empty.
// ----------------------------------------------------------------------------
module murmur3_word_stream_hash import mw3_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mw3_in_if.sink             i_in,
    mw3_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_x;
    logic [WORD_W-1:0] r_h;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_prod;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_last;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_hash;

    logic              busy;
    t_uword            uw;
    logic              in_fire;
    logic              cfg_wr;
    logic              out_full;
    logic              emit;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [WORD_W-1:0] mul_p;
    logic [WORD_W-1:0] kval;
    logic [WORD_W-1:0] rnd_t;
    logic [WORD_W-1:0] fin_t;
    logic [WORD_W-1:0] acc_xs;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[3] == REG_SEED);
    assign prdata   = (paddr[3] == REG_SEED) ? r_seed : '0;

    assign i_in.ready     = !busy;
    assign in_fire        = i_in.valid && !busy;
    assign o_out.valid    = r_out_valid;
    assign o_out.hash_out = r_out_hash;
    assign out_full       = r_out_valid && !o_out.ready;
    assign emit           = (uw.alu == ALU_OUT) && !out_full;

    mw3_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_fire),
        .i_last     (r_last),
        .i_out_full (out_full),
        .o_busy     (busy),
        .o_uw       (uw)
    );

    assign kval   = kconst(uw.kst);
    assign mul_a  = uw.x_hi ? r_x[63:32] : r_x[31:0];
    assign mul_b  = uw.k_hi ? kval[63:32] : kval[31:0];
    assign mul_p  = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
    assign rnd_t  = {r_h[36:0] ^ r_acc[36:0], r_h[63:37] ^ r_acc[63:37]};
    assign fin_t  = r_h ^ {29'd0, r_cnt, 3'b000};
    assign acc_xs = r_acc ^ {33'd0, r_acc[63:33]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_seed <= pwdata;
            end
            if (in_fire) begin
                r_last <= i_in.last;
                if (r_cnt != CNT_MAX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (emit) begin
                r_cnt <= '0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x <= i_in.word;
            if (r_cnt == '0) begin
                r_h <= r_seed;
            end
        end
        if (uw.mul_en) begin
            r_prod <= mul_p;
        end
        case (uw.acc)
            ACC_LOAD:  r_acc <= r_prod;
            ACC_ADDHI: r_acc <= r_acc + {r_prod[31:0], 32'd0};
            default: ;
        endcase
        case (uw.alu)
            ALU_ROT31: r_x <= {r_acc[32:0], r_acc[63:33]};
            ALU_ROUND: r_h <= rnd_t + {rnd_t[61:0], 2'b00} + ROUND_ADD;
            ALU_FIN:   r_x <= fin_t ^ {33'd0, fin_t[63:33]};
            ALU_XS:    r_x <= acc_xs;
            ALU_OUT: begin
                if (emit) begin
                    r_out_hash <= acc_xs;
                end
            end
            default: ;
        endcase
    end

endmodule
